// ----- rtl/rtp_header_parser_core_macros.svh -----
// ----------------------------------------------------------------------------
// rtp_header_parser_core_macros
// assertion helpers shared by the rtp header parser modules
// ----------------------------------------------------------------------------
`ifndef RTP_HEADER_PARSER_CORE_MACROS_SVH
`define RTP_HEADER_PARSER_CORE_MACROS_SVH

// condition that must hold at every clock edge outside reset
`define RHP_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("rhp: invariant violated");

// consequence that must hold in the cycle after the trigger
`define RHP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rhp: next-cycle check failed");

`endif

// ----- rtl/rhp_pkg.sv -----
// ----------------------------------------------------------------------------
// rhp_pkg
// shared types and constants for the rtp header parser
// ----------------------------------------------------------------------------
package rhp_pkg;

  // packet and field limits
  localparam logic [15:0] MAX_PACKET_BYTES = 16'hFFFF;
  localparam int unsigned TWCC_ID_W        = 4;
  localparam logic [3:0]  TWCC_ID_RESET    = 4'd1;
  localparam logic [15:0] BEDE_PROFILE     = 16'hBEDE;
  localparam logic [1:0]  RTP_VERSION      = 2'd2;
  localparam logic [6:0]  FIXED_HDR_BYTES  = 7'd12;

  // result queue sizing
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = FIFO_PTR_W + 1;

  // parse phases
  typedef enum logic [2:0] {
    PH_FIXED   = 3'd0,
    PH_CSRC    = 3'd1,
    PH_EXTHDR  = 3'd2,
    PH_EXTBODY = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_DEAD    = 3'd5
  } phase_t;

  // summary status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_SHORT      = 3'd1,
    ST_VERSION    = 3'd2,
    ST_CSRC       = 3'd3,
    ST_EXT_HEADER = 3'd4,
    ST_EXT_TRUNC  = 3'd5,
    ST_OVERRUN    = 3'd6
  } status_t;

  // one result item
  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic        marker;
    logic [6:0]  media_type;
    logic [15:0] seq_num;
    logic [31:0] timestamp;
    logic [31:0] ssrc;
    logic [15:0] transport_sequence;
    status_t     status;
    logic        last_of_run;
  } rhp_result_t;

  // up to two results produced by one input request
  typedef struct packed {
    logic [1:0]  count;
    rhp_result_t first;
    rhp_result_t second;
  } rhp_push_t;

endpackage

// ----- rtl/rhp_byte_if.sv -----
// ----------------------------------------------------------------------------
// rhp_byte_if
// valid/ready channel carrying one packet byte per request
// ----------------------------------------------------------------------------
interface rhp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_packet;

  modport source (output valid, output data_byte, output end_of_packet, input ready);
  modport sink   (input valid, input data_byte, input end_of_packet, output ready);
endinterface

// ----- rtl/rhp_result_if.sv -----
// ----------------------------------------------------------------------------
// rhp_result_if
// valid/ready channel carrying one payload byte or packet summary per request
// ----------------------------------------------------------------------------
interface rhp_result_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  payload_byte;
  logic        marker;
  logic [6:0]  media_type;
  logic [15:0] seq_num;
  logic [31:0] timestamp;
  logic [31:0] ssrc;
  logic [15:0] transport_sequence;
  logic [2:0]  status;
  logic        last_of_run;

  modport source (
    output valid, output kind, output payload_byte, output marker, output media_type,
    output seq_num, output timestamp, output ssrc, output transport_sequence,
    output status, output last_of_run, input ready
  );
  modport sink (
    input valid, input kind, input payload_byte, input marker, input media_type,
    input seq_num, input timestamp, input ssrc, input transport_sequence,
    input status, input last_of_run, output ready
  );
endinterface

// ----- rtl/rhp_parser.sv -----
// ----------------------------------------------------------------------------
// rhp_parser
// per-byte header walk: fixed header, csrc skip, one-byte extension elements,
// payload pass-through and end-of-packet summary
// ----------------------------------------------------------------------------
`include "rtp_header_parser_core_macros.svh"

module rhp_parser import rhp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [TWCC_ID_W-1:0] cfg_data,
  input  logic                 take,
  input  logic [7:0]           data_byte,
  input  logic                 end_of_packet,
  output rhp_push_t            push
);

  // element capture codes
  localparam logic [1:0] CAP_NONE = 2'd0;
  localparam logic [1:0] CAP_LOW  = 2'd1;
  localparam logic [1:0] CAP_HIGH = 2'd2;

  // configuration
  logic [TWCC_ID_W-1:0] twcc_extension_id;

  // packet state
  logic [15:0] byte_position;
  phase_t      parse_phase;
  logic [3:0]  csrc_words;
  logic        extension_present;
  logic [15:0] extension_profile;
  logic [15:0] extension_words;
  logic [18:0] ext_end_pos;
  logic [4:0]  element_bytes_left;
  logic [1:0]  element_capture;
  logic        marker_bit;
  logic [6:0]  type_reg;
  logic [15:0] sequence_reg;
  logic [31:0] timestamp_reg;
  logic [31:0] source_reg;
  logic [15:0] transport_reg;
  logic        version_bad;
  logic        element_overrun;

  // state after this byte, before the end-of-packet clear
  logic [15:0] byte_position_upd;
  phase_t      parse_phase_upd;
  logic [3:0]  csrc_words_upd;
  logic        extension_present_upd;
  logic [15:0] extension_profile_upd;
  logic [15:0] extension_words_upd;
  logic [18:0] ext_end_pos_upd;
  logic [4:0]  element_bytes_left_upd;
  logic [1:0]  element_capture_upd;
  logic        marker_bit_upd;
  logic [6:0]  type_reg_upd;
  logic [15:0] sequence_reg_upd;
  logic [31:0] timestamp_reg_upd;
  logic [31:0] source_reg_upd;
  logic [15:0] transport_reg_upd;
  logic        version_bad_upd;
  logic        element_overrun_upd;

  logic        in_range;
  logic        emit;
  logic        last;
  logic [6:0]  header_end;
  logic [16:0] pos_plus1;
  logic [1:0]  hdr_off;
  logic [4:0]  elem_len;
  logic [18:0] elem_limit;
  logic [6:0]  header_end_upd;
  status_t     status_upd;
  rhp_result_t payload_res;
  rhp_result_t summary_res;

  // positions derived from the current state
  assign in_range   = byte_position < MAX_PACKET_BYTES;
  assign header_end = FIXED_HDR_BYTES + {1'b0, csrc_words, 2'b00};
  assign pos_plus1  = {1'b0, byte_position} + 17'd1;
  assign hdr_off    = byte_position[1:0] - header_end[1:0];
  assign elem_len   = {1'b0, data_byte[3:0]} + 5'd1;
  assign elem_limit = {2'b00, pos_plus1} + {14'd0, elem_len};
  assign last       = take & end_of_packet;

  // byte walk
  always_comb begin
    byte_position_upd      = byte_position;
    parse_phase_upd        = parse_phase;
    csrc_words_upd         = csrc_words;
    extension_present_upd  = extension_present;
    extension_profile_upd  = extension_profile;
    extension_words_upd    = extension_words;
    ext_end_pos_upd        = ext_end_pos;
    element_bytes_left_upd = element_bytes_left;
    element_capture_upd    = element_capture;
    marker_bit_upd         = marker_bit;
    type_reg_upd           = type_reg;
    sequence_reg_upd       = sequence_reg;
    timestamp_reg_upd      = timestamp_reg;
    source_reg_upd         = source_reg;
    transport_reg_upd      = transport_reg;
    version_bad_upd        = version_bad;
    element_overrun_upd    = element_overrun;
    emit                   = 1'b0;
    if (take && in_range) begin
      byte_position_upd = byte_position + 16'd1;
      case (parse_phase)
        PH_FIXED: begin
          if (byte_position == 16'd0) begin
            version_bad_upd       = data_byte[7:6] != RTP_VERSION;
            extension_present_upd = data_byte[4];
            csrc_words_upd        = data_byte[3:0];
          end else if (byte_position == 16'd1) begin
            marker_bit_upd = data_byte[7];
            type_reg_upd   = data_byte[6:0];
          end else if (byte_position < 16'd4) begin
            sequence_reg_upd = {sequence_reg[7:0], data_byte};
          end else if (byte_position < 16'd8) begin
            timestamp_reg_upd = {timestamp_reg[23:0], data_byte};
          end else begin
            source_reg_upd = {source_reg[23:0], data_byte};
          end
          if (byte_position == 16'd11) begin
            if (version_bad) begin
              parse_phase_upd = PH_DEAD;
            end else if (csrc_words != 4'd0) begin
              parse_phase_upd = PH_CSRC;
            end else if (extension_present) begin
              parse_phase_upd = PH_EXTHDR;
            end else begin
              parse_phase_upd = PH_PAYLOAD;
            end
          end
        end
        PH_CSRC: begin
          if (pos_plus1 >= {10'd0, header_end}) begin
            parse_phase_upd = extension_present ? PH_EXTHDR : PH_PAYLOAD;
          end
        end
        PH_EXTHDR: begin
          if (!hdr_off[1]) begin
            extension_profile_upd = {extension_profile[7:0], data_byte};
          end else begin
            extension_words_upd = {extension_words[7:0], data_byte};
          end
          if (hdr_off == 2'd3) begin
            ext_end_pos_upd = {12'd0, header_end} + 19'd4
                            + {1'b0, extension_words_upd, 2'b00};
            element_bytes_left_upd = 5'd0;
            element_capture_upd    = CAP_NONE;
            parse_phase_upd = (extension_words_upd == 16'd0) ? PH_PAYLOAD : PH_EXTBODY;
          end
        end
        PH_EXTBODY: begin
          if (extension_profile == BEDE_PROFILE && !element_overrun) begin
            if (element_bytes_left == 5'd0) begin
              // element header byte; zero is padding
              if (data_byte != 8'd0) begin
                if (elem_limit > ext_end_pos) begin
                  element_overrun_upd = 1'b1;
                end else begin
                  element_bytes_left_upd = elem_len;
                  element_capture_upd = (data_byte[7:4] == twcc_extension_id &&
                                         elem_len == 5'd2) ? CAP_HIGH : CAP_NONE;
                end
              end
            end else begin
              if (element_capture == CAP_HIGH) begin
                transport_reg_upd   = {data_byte, 8'h00};
                element_capture_upd = CAP_LOW;
              end else if (element_capture == CAP_LOW) begin
                transport_reg_upd   = {transport_reg[15:8], data_byte};
                element_capture_upd = CAP_NONE;
              end
              element_bytes_left_upd = element_bytes_left - 5'd1;
            end
          end
          if ({2'b00, pos_plus1} >= ext_end_pos) begin
            parse_phase_upd = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          emit = !element_overrun;
        end
        default: begin
        end
      endcase
    end
  end

  // summary status in check order
  assign header_end_upd = FIXED_HDR_BYTES + {1'b0, csrc_words_upd, 2'b00};

  always_comb begin
    if (byte_position_upd < {9'd0, FIXED_HDR_BYTES}) begin
      status_upd = ST_SHORT;
    end else if (version_bad_upd) begin
      status_upd = ST_VERSION;
    end else if (byte_position_upd < {9'd0, header_end_upd}) begin
      status_upd = ST_CSRC;
    end else if (extension_present_upd) begin
      if ({1'b0, byte_position_upd} < {10'd0, header_end_upd} + 17'd4) begin
        status_upd = ST_EXT_HEADER;
      end else if ({3'd0, byte_position_upd} < ext_end_pos_upd) begin
        status_upd = ST_EXT_TRUNC;
      end else if (element_overrun_upd) begin
        status_upd = ST_OVERRUN;
      end else begin
        status_upd = ST_OK;
      end
    end else begin
      status_upd = ST_OK;
    end
  end

  // result items
  always_comb begin
    payload_res              = '0;
    payload_res.kind         = 1'b0;
    payload_res.payload_byte = data_byte;
    payload_res.status       = ST_OK;
    payload_res.last_of_run  = !end_of_packet;

    summary_res             = '0;
    summary_res.kind        = 1'b1;
    summary_res.status      = status_upd;
    summary_res.last_of_run = 1'b1;
    if (status_upd == ST_OK || status_upd == ST_EXT_HEADER ||
        status_upd == ST_EXT_TRUNC || status_upd == ST_OVERRUN) begin
      summary_res.marker     = marker_bit_upd;
      summary_res.media_type = type_reg_upd;
      summary_res.seq_num    = sequence_reg_upd;
      summary_res.timestamp  = timestamp_reg_upd;
      summary_res.ssrc       = source_reg_upd;
    end
    if (status_upd == ST_OK) begin
      summary_res.transport_sequence = transport_reg_upd;
    end

    push.first  = emit ? payload_res : summary_res;
    push.second = summary_res;
    if (emit && last) begin
      push.count = 2'd2;
    end else if (emit || last) begin
      push.count = 2'd1;
    end else begin
      push.count = 2'd0;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      twcc_extension_id <= TWCC_ID_RESET;
    end else if (cfg_we) begin
      twcc_extension_id <= cfg_data;
    end
  end

  // packet state, cleared after each summary
  always_ff @(posedge clk) begin
    if (rst || last) begin
      byte_position      <= '0;
      parse_phase        <= PH_FIXED;
      csrc_words         <= '0;
      extension_present  <= 1'b0;
      extension_profile  <= '0;
      extension_words    <= '0;
      ext_end_pos        <= '0;
      element_bytes_left <= '0;
      element_capture    <= CAP_NONE;
      marker_bit         <= 1'b0;
      type_reg           <= '0;
      sequence_reg       <= '0;
      timestamp_reg      <= '0;
      source_reg         <= '0;
      transport_reg      <= '0;
      version_bad        <= 1'b0;
      element_overrun    <= 1'b0;
    end else if (take) begin
      byte_position      <= byte_position_upd;
      parse_phase        <= parse_phase_upd;
      csrc_words         <= csrc_words_upd;
      extension_present  <= extension_present_upd;
      extension_profile  <= extension_profile_upd;
      extension_words    <= extension_words_upd;
      ext_end_pos        <= ext_end_pos_upd;
      element_bytes_left <= element_bytes_left_upd;
      element_capture    <= element_capture_upd;
      marker_bit         <= marker_bit_upd;
      type_reg           <= type_reg_upd;
      sequence_reg       <= sequence_reg_upd;
      timestamp_reg      <= timestamp_reg_upd;
      source_reg         <= source_reg_upd;
      transport_reg      <= transport_reg_upd;
      version_bad        <= version_bad_upd;
      element_overrun    <= element_overrun_upd;
    end
  end

  // checks
  `RHP_ASSERT_NEXT(a_clear_after_end, take && end_of_packet,
                   byte_position == 16'd0 && parse_phase == PH_FIXED)
  `RHP_ASSERT_ALWAYS(a_dead_means_bad_version, parse_phase != PH_DEAD || version_bad)
  `RHP_ASSERT_ALWAYS(a_two_results_only_on_end, push.count != 2'd2 || (take && end_of_packet))

endmodule

// ----- rtl/rhp_result_fifo.sv -----
// ----------------------------------------------------------------------------
// rhp_result_fifo
// small result queue taking up to two results per cycle, one out per request
// ----------------------------------------------------------------------------
`include "rtp_header_parser_core_macros.svh"

module rhp_result_fifo import rhp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  rhp_push_t  push,
  output logic       room,
  rhp_result_if.source result_out
);

  rhp_result_t           slots [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;
  logic [FIFO_CNT_W-1:0] count_next;
  logic                  pop;
  rhp_result_t           head;

  // room for a full two-result push
  assign room = count <= FIFO_CNT_W'(FIFO_DEPTH - 2);
  assign pop  = result_out.valid & result_out.ready;
  assign count_next = count + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_PTR_W'(push.count);
      rd_ptr <= rd_ptr + FIFO_PTR_W'(pop);
      count  <= count_next;
    end
  end

  // slot writes
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      slots[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      slots[wr_ptr + FIFO_PTR_W'(1)] <= push.second;
    end
  end

  // head of queue to the output channel
  assign head = slots[rd_ptr];
  assign result_out.valid              = count != '0;
  assign result_out.kind               = head.kind;
  assign result_out.payload_byte       = head.payload_byte;
  assign result_out.marker             = head.marker;
  assign result_out.media_type         = head.media_type;
  assign result_out.seq_num            = head.seq_num;
  assign result_out.timestamp          = head.timestamp;
  assign result_out.ssrc               = head.ssrc;
  assign result_out.transport_sequence = head.transport_sequence;
  assign result_out.status             = head.status;
  assign result_out.last_of_run        = head.last_of_run;

  // checks
  `RHP_ASSERT_ALWAYS(a_count_bounded, count <= FIFO_CNT_W'(FIFO_DEPTH))
  `RHP_ASSERT_ALWAYS(a_push_needs_room, push.count == 2'd0 || room)
  `RHP_ASSERT_ALWAYS(a_empty_pointers_meet, count != '0 || wr_ptr == rd_ptr)

endmodule

// ----- rtl/rtp_header_parser_core.sv -----
// ----------------------------------------------------------------------------
// rtp_header_parser_core
// first result: offered in the cycle after its byte is taken, queue empty
// throughput: 1 byte per cycle; stalls only while 3 or more results wait
// reset: rst clears parse state and result queue, element id returns to 1
// ----------------------------------------------------------------------------
module rtp_header_parser_core import rhp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [TWCC_ID_W-1:0] cfg_data,
  rhp_byte_if.sink             byte_in,
  rhp_result_if.source         result_out
);

  logic      room;
  logic      take;
  rhp_push_t push;

  // input handshake gated by queue space
  assign byte_in.ready = room;
  assign take          = byte_in.valid & room;

  // header walk
  rhp_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .take          (take),
    .data_byte     (byte_in.data_byte),
    .end_of_packet (byte_in.end_of_packet),
    .push          (push)
  );

  // result queue
  rhp_result_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .room       (room),
    .result_out (result_out)
  );

endmodule
